[rtl/pdpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpc_pkg
// Shared types and codes of the depth-plane polygon clipper.
// ----------------------------------------------------------------------------
package pdpc_pkg;

    // token kinds moving down the clip chain
    localparam logic [1:0] KIND_VERT = 2'd0;  // a vertex
    localparam logic [1:0] KIND_EOI  = 2'd1;  // end of one input item
    localparam logic [1:0] KIND_EOP  = 2'd2;  // end of the polygon's last item

    // configuration register indexes
    localparam int         CFG_IDX_W = 1;
    localparam logic [0:0] REG_NEAR  = 1'b0;
    localparam logic [0:0] REG_FAR   = 1'b1;

    // control part of a token: kind and the plane enables of its polygon
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] en;
    } t_ctl;

endpackage

[rtl/pdpc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpc_cell
// One Sutherland-Hodgman clip cell: clips a token stream against one plane,
// with a multiply stage and a bit-serial divider for edge crossings.
// ----------------------------------------------------------------------------
module pdpc_cell #(
    parameter int W      = 16,
    parameter bit IS_FAR = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic signed [W-1:0]   i_plane,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pdpc_pkg::t_ctl        i_in_ctl,
    input  logic signed [W-1:0]   i_in_x,
    input  logic signed [W-1:0]   i_in_y,
    input  logic signed [W-1:0]   i_in_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pdpc_pkg::t_ctl        o_out_ctl,
    output logic signed [W-1:0]   o_out_x,
    output logic signed [W-1:0]   o_out_y,
    output logic signed [W-1:0]   o_out_z
);

    localparam int PW = 2 * W;
    localparam int CW = $clog2(PW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIX  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    localparam logic [PW-1:0] MAG_HI = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [PW-1:0] MAG_LO = {{(PW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0]  Q_HI   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  Q_LO   = {1'b1, {(W-1){1'b0}}};

    logic [2:0]            r_state, n_state;
    pdpc_pkg::t_ctl        r_ctl;
    logic signed [W-1:0]   r_vx, r_vy, r_vz;
    logic signed [W-1:0]   r_prev_x, r_prev_y, r_prev_z;
    logic                  r_prev_in;
    logic signed [W-1:0]   r_first_x, r_first_y, r_first_z;
    logic                  r_need_close, r_emitted, r_started;
    logic signed [W-1:0]   r_sx, r_sy, r_dx, r_dy, r_dz, r_n;
    logic signed [PW-1:0]  r_px, r_py;
    logic [PW-1:0]         r_numx, r_numy;
    logic [W-1:0]          r_remx, r_remy;
    logic [W-1:0]          r_dmag;
    logic                  r_dzero;
    logic                  r_negx, r_negy, r_nzx, r_nzy, r_posx, r_posy;
    logic [CW-1:0]         r_cnt;
    logic signed [W-1:0]   r_cx, r_cy;
    logic                  r_em_cross, r_em_vert, r_em_close, r_em_end;
    logic                  r_out_valid;
    pdpc_pkg::t_ctl        r_out_ctl;
    logic signed [W-1:0]   r_out_x, r_out_y, r_out_z;

    logic                  ins;
    logic                  can_push;
    logic                  push;
    logic [W:0]            tx, ty;
    logic                  qbx, qby;
    logic [PW-1:0]         magx, magy;
    logic [W-1:0]          qx, qy;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_ctl   = r_out_ctl;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;

    assign can_push = !r_out_valid || i_out_ready;
    assign push     = (r_state == S_EMIT) && can_push &&
                      (r_em_cross || r_em_vert || r_em_close || r_em_end);

    always_comb begin
        if (!r_ctl.en[IS_FAR]) begin
            ins = 1'b1;
        end else if (IS_FAR) begin
            ins = (r_vz > i_plane);
        end else begin
            ins = (r_vz < i_plane);
        end
    end

    // one restoring step per cycle for both quotients
    always_comb begin
        tx  = {r_remx, r_numx[PW-1]};
        ty  = {r_remy, r_numy[PW-1]};
        qbx = (tx >= {1'b0, r_dmag});
        qby = (ty >= {1'b0, r_dmag});
    end

    // saturate the quotient magnitudes and apply signs
    always_comb begin
        magx = r_numx;
        magy = r_numy;
        if (r_dzero) begin
            qx = r_nzx ? (r_posx ? Q_HI : Q_LO) : '0;
            qy = r_nzy ? (r_posy ? Q_HI : Q_LO) : '0;
        end else begin
            if (!r_negx) begin
                qx = (magx > MAG_HI) ? Q_HI : magx[W-1:0];
            end else begin
                qx = (magx > MAG_LO) ? Q_LO : W'(-magx[W-1:0]);
            end
            if (!r_negy) begin
                qy = (magy > MAG_HI) ? Q_HI : magy[W-1:0];
            end else begin
                qy = (magy > MAG_LO) ? Q_LO : W'(-magy[W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_z     <= '0;
            r_prev_in    <= 1'b0;
            r_need_close <= 1'b0;
            r_emitted    <= 1'b0;
            r_started    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_em_cross   <= 1'b0;
            r_em_vert    <= 1'b0;
            r_em_close   <= 1'b0;
            r_em_end     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ctl <= i_in_ctl;
                        r_vx  <= i_in_x;
                        r_vy  <= i_in_y;
                        r_vz  <= i_in_z;
                    end
                end
                S_EVAL: begin
                    r_em_vert  <= (r_ctl.kind == pdpc_pkg::KIND_VERT) && ins;
                    r_em_cross <= (r_ctl.kind == pdpc_pkg::KIND_VERT) && r_started &&
                                  (r_prev_in != ins);
                    r_em_close <= (r_ctl.kind == pdpc_pkg::KIND_EOP) &&
                                  r_need_close && r_emitted;
                    r_em_end   <= (r_ctl.kind != pdpc_pkg::KIND_VERT);
                    if (r_ctl.kind == pdpc_pkg::KIND_VERT) begin
                        r_prev_x  <= r_vx;
                        r_prev_y  <= r_vy;
                        r_prev_z  <= r_vz;
                        r_prev_in <= ins;
                        if (!r_started) begin
                            r_started    <= 1'b1;
                            r_emitted    <= 1'b0;
                            r_need_close <= !ins;
                        end else if (r_prev_in != ins) begin
                            if (r_prev_in) begin
                                // leaving: start at the previous vertex
                                r_sx <= r_prev_x;
                                r_sy <= r_prev_y;
                                r_dx <= r_vx - r_prev_x;
                                r_dy <= r_vy - r_prev_y;
                                r_dz <= r_vz - r_prev_z;
                                r_n  <= i_plane - r_prev_z;
                            end else begin
                                r_sx <= r_vx;
                                r_sy <= r_vy;
                                r_dx <= r_prev_x - r_vx;
                                r_dy <= r_prev_y - r_vy;
                                r_dz <= r_prev_z - r_vz;
                                r_n  <= i_plane - r_vz;
                            end
                        end
                    end else if (r_ctl.kind == pdpc_pkg::KIND_EOP) begin
                        r_started    <= 1'b0;
                        r_emitted    <= 1'b0;
                        r_need_close <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_px <= r_dx * r_n;
                    r_py <= r_dy * r_n;
                end
                S_PREP: begin
                    r_numx  <= r_px[PW-1] ? PW'(-r_px) : PW'(r_px);
                    r_numy  <= r_py[PW-1] ? PW'(-r_py) : PW'(r_py);
                    r_remx  <= '0;
                    r_remy  <= '0;
                    r_dmag  <= r_dz[W-1] ? W'(-r_dz) : W'(r_dz);
                    r_dzero <= (r_dz == '0);
                    r_nzx   <= (r_px != '0);
                    r_nzy   <= (r_py != '0);
                    r_posx  <= !r_px[PW-1];
                    r_posy  <= !r_py[PW-1];
                    r_negx  <= r_px[PW-1] ^ r_dz[W-1];
                    r_negy  <= r_py[PW-1] ^ r_dz[W-1];
                    r_cnt   <= CW'(PW);
                end
                S_DIV: begin
                    r_remx <= qbx ? W'(tx - {1'b0, r_dmag}) : tx[W-1:0];
                    r_remy <= qby ? W'(ty - {1'b0, r_dmag}) : ty[W-1:0];
                    r_numx <= {r_numx[PW-2:0], qbx};
                    r_numy <= {r_numy[PW-2:0], qby};
                    r_cnt  <= r_cnt - 1'b1;
                end
                S_FIX: begin
                    r_cx <= r_sx + $signed(qx);
                    r_cy <= r_sy + $signed(qy);
                end
                S_EMIT: begin
                    if (can_push) begin
                        if (r_em_cross) begin
                            r_em_cross <= 1'b0;
                            r_out_ctl  <= '{kind: pdpc_pkg::KIND_VERT, en: r_ctl.en};
                            r_out_x    <= r_cx;
                            r_out_y    <= r_cy;
                            r_out_z    <= i_plane;
                            if (!r_emitted) begin
                                r_emitted <= 1'b1;
                                r_first_x <= r_cx;
                                r_first_y <= r_cy;
                                r_first_z <= i_plane;
                            end
                        end else if (r_em_vert) begin
                            r_em_vert <= 1'b0;
                            r_out_ctl <= '{kind: pdpc_pkg::KIND_VERT, en: r_ctl.en};
                            r_out_x   <= r_vx;
                            r_out_y   <= r_vy;
                            r_out_z   <= r_vz;
                            if (!r_emitted) begin
                                r_emitted <= 1'b1;
                                r_first_x <= r_vx;
                                r_first_y <= r_vy;
                                r_first_z <= r_vz;
                            end
                        end else if (r_em_close) begin
                            // repeat the first emitted vertex to close the ring
                            r_em_close <= 1'b0;
                            r_out_ctl  <= '{kind: pdpc_pkg::KIND_VERT, en: r_ctl.en};
                            r_out_x    <= r_first_x;
                            r_out_y    <= r_first_y;
                            r_out_z    <= r_first_z;
                        end else if (r_em_end) begin
                            r_em_end  <= 1'b0;
                            r_out_ctl <= r_ctl;
                            r_out_x   <= r_vx;
                            r_out_y   <= r_vy;
                            r_out_z   <= r_vz;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_ctl.kind == pdpc_pkg::KIND_VERT && r_started && (r_prev_in != ins)) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_MUL:  n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX:  n_state = S_EMIT;
            S_EMIT: begin
                if (!(r_em_cross || r_em_vert || r_em_close || r_em_end)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/pdpc_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpc_out
// Result formatter: holds back one vertex to flag the polygon's last result
// and turns an empty closing item into the fully-clipped marker.
// ----------------------------------------------------------------------------
module pdpc_out #(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pdpc_pkg::t_ctl        i_in_ctl,
    input  logic signed [W-1:0]   i_in_x,
    input  logic signed [W-1:0]   i_in_y,
    input  logic signed [W-1:0]   i_in_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [W-1:0]   o_x,
    output logic signed [W-1:0]   o_y,
    output logic signed [W-1:0]   o_z,
    output logic                  o_end,
    output logic                  o_clipped
);

    logic                 r_pend_valid;
    logic signed [W-1:0]  r_pend_x, r_pend_y, r_pend_z;
    logic                 r_out_valid;
    logic signed [W-1:0]  r_out_x, r_out_y, r_out_z;
    logic                 r_out_end, r_out_clip;
    logic                 take;

    assign o_in_ready = !r_out_valid || i_ready;
    assign take       = i_in_valid && o_in_ready;
    assign o_valid    = r_out_valid;
    assign o_x        = r_out_x;
    assign o_y        = r_out_y;
    assign o_z        = r_out_z;
    assign o_end      = r_out_end;
    assign o_clipped  = r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                case (i_in_ctl.kind)
                    pdpc_pkg::KIND_VERT: begin
                        r_out_valid  <= r_pend_valid;
                        r_out_x      <= r_pend_x;
                        r_out_y      <= r_pend_y;
                        r_out_z      <= r_pend_z;
                        r_out_end    <= 1'b0;
                        r_out_clip   <= 1'b0;
                        r_pend_valid <= 1'b1;
                        r_pend_x     <= i_in_x;
                        r_pend_y     <= i_in_y;
                        r_pend_z     <= i_in_z;
                    end
                    pdpc_pkg::KIND_EOP: begin
                        r_out_valid  <= 1'b1;
                        r_out_end    <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_out_x      <= r_pend_valid ? r_pend_x : '0;
                        r_out_y      <= r_pend_valid ? r_pend_y : '0;
                        r_out_z      <= r_pend_valid ? r_pend_z : '0;
                        r_out_clip   <= !r_pend_valid;
                    end
                    default: begin
                        // end of a non-closing item: flush what is held
                        r_out_valid  <= r_pend_valid;
                        r_out_x      <= r_pend_x;
                        r_out_y      <= r_pend_y;
                        r_out_z      <= r_pend_z;
                        r_out_end    <= 1'b0;
                        r_out_clip   <= 1'b0;
                        r_pend_valid <= 1'b0;
                    end
                endcase
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[rtl/polygon_depth_plane_clipper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_depth_plane_clipper
// Clips a closed polygon vertex stream against a near and a far depth plane.
// ----------------------------------------------------------------------------
// Input beats carry one vertex each; the beat with i_last_vertex set closes
// the polygon and repeats its first vertex. Plane enables are taken from the
// polygon's first beat. Result beats carry clipped vertices; o_poly_end marks
// the last result of a polygon, and a polygon with nothing left in its
// closing beat gives one beat with o_all_clipped set and zero coordinates.
// Each vertex beat is split into a vertex token and an end token that run
// through two clip cells (near, then far) and a formatter, each with its own
// output register. A cell evaluates each token and emits each vertex it
// keeps; when the edge crosses its plane it first finds the crossing with a
// multiply stage and its bit-serial divider. The input is taken again once
// the near cell has the end token, so a new beat can enter while the far
// cell and the formatter still work on the last one.
// A stalled receiver backs up the chain and then the input through o_ready.
// Reset clears all control state and loads near 0 and far -32768.
// The user must write planes through i_cfg_wen only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module polygon_depth_plane_clipper #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [pdpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]              i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_vert_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vert_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vert_z,
    input  logic                                i_clip_near,
    input  logic                                i_clip_far,
    input  logic                                i_last_vertex,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [COORD_WIDTH-1:0]       o_out_x,
    output logic signed [COORD_WIDTH-1:0]       o_out_y,
    output logic signed [COORD_WIDTH-1:0]       o_out_z,
    output logic                                o_poly_end,
    output logic                                o_all_clipped
);

    localparam int W = COORD_WIDTH;

    localparam logic [1:0] FE_IDLE = 2'd0;
    localparam logic [1:0] FE_VERT = 2'd1;
    localparam logic [1:0] FE_END  = 2'd2;

    logic signed [W-1:0]  r_near, r_far;
    logic [1:0]           r_fe_state;
    logic [1:0]           r_en;
    logic                 r_in_poly;
    logic                 r_last;
    logic signed [W-1:0]  r_x, r_y, r_z;

    pdpc_pkg::t_ctl       fe_ctl;
    logic                 fe_valid, c0_ready;
    logic                 c0_valid, c1_ready;
    pdpc_pkg::t_ctl       c0_ctl;
    logic signed [W-1:0]  c0_x, c0_y, c0_z;
    logic                 c1_valid, fo_ready;
    pdpc_pkg::t_ctl       c1_ctl;
    logic signed [W-1:0]  c1_x, c1_y, c1_z;

    assign o_ready  = (r_fe_state == FE_IDLE);
    assign fe_valid = (r_fe_state != FE_IDLE);

    always_comb begin
        fe_ctl.en = r_en;
        if (r_fe_state == FE_VERT) begin
            fe_ctl.kind = pdpc_pkg::KIND_VERT;
        end else if (r_last) begin
            fe_ctl.kind = pdpc_pkg::KIND_EOP;
        end else begin
            fe_ctl.kind = pdpc_pkg::KIND_EOI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near     <= '0;
            r_far      <= {1'b1, {(W-1){1'b0}}};
            r_fe_state <= FE_IDLE;
            r_en       <= 2'b00;
            r_in_poly  <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    pdpc_pkg::REG_NEAR: r_near <= i_cfg_data;
                    pdpc_pkg::REG_FAR:  r_far  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_fe_state)
                FE_IDLE: begin
                    if (i_valid) begin
                        r_x        <= i_vert_x;
                        r_y        <= i_vert_y;
                        r_z        <= i_vert_z;
                        r_last     <= i_last_vertex;
                        r_in_poly  <= !i_last_vertex;
                        r_fe_state <= FE_VERT;
                        // sample enables on the polygon's first beat
                        if (!r_in_poly) begin
                            r_en <= {i_clip_far, i_clip_near};
                        end
                    end
                end
                FE_VERT: begin
                    if (c0_ready) begin
                        r_fe_state <= FE_END;
                    end
                end
                FE_END: begin
                    if (c0_ready) begin
                        r_fe_state <= FE_IDLE;
                    end
                end
                default: r_fe_state <= FE_IDLE;
            endcase
        end
    end

    pdpc_cell #(.W(W), .IS_FAR(1'b0)) u_near (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_plane     (r_near),
        .i_in_valid  (fe_valid),
        .o_in_ready  (c0_ready),
        .i_in_ctl    (fe_ctl),
        .i_in_x      (r_x),
        .i_in_y      (r_y),
        .i_in_z      (r_z),
        .o_out_valid (c0_valid),
        .i_out_ready (c1_ready),
        .o_out_ctl   (c0_ctl),
        .o_out_x     (c0_x),
        .o_out_y     (c0_y),
        .o_out_z     (c0_z)
    );

    pdpc_cell #(.W(W), .IS_FAR(1'b1)) u_far (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_plane     (r_far),
        .i_in_valid  (c0_valid),
        .o_in_ready  (c1_ready),
        .i_in_ctl    (c0_ctl),
        .i_in_x      (c0_x),
        .i_in_y      (c0_y),
        .i_in_z      (c0_z),
        .o_out_valid (c1_valid),
        .i_out_ready (fo_ready),
        .o_out_ctl   (c1_ctl),
        .o_out_x     (c1_x),
        .o_out_y     (c1_y),
        .o_out_z     (c1_z)
    );

    pdpc_out #(.W(W)) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (c1_valid),
        .o_in_ready (fo_ready),
        .i_in_ctl   (c1_ctl),
        .i_in_x     (c1_x),
        .i_in_y     (c1_y),
        .i_in_z     (c1_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_x        (o_out_x),
        .o_y        (o_out_y),
        .o_z        (o_out_z),
        .o_end      (o_poly_end),
        .o_clipped  (o_all_clipped)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth-plane polygon clipper.
// ----------------------------------------------------------------------------
// Polygons stream in as vertex beats and an in-bench clip model predicts the
// result beats. A short table of directed polygons comes first, followed by
// random polygons and loose beats under several plane settings. Both sides
// insert random gaps, and results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW          = 16;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE      = 300;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vert_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 pend;
        logic                 clipped;
    } clip_res_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 cn;
        logic                 cf;
        logic                 last;
        logic                 typed;
        clip_res_t            res;
    } vec_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wen = 1'b0;
    logic [pdpc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CW-1:0]        i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [CW-1:0] i_vert_x = '0;
    logic signed [CW-1:0] i_vert_y = '0;
    logic signed [CW-1:0] i_vert_z = '0;
    logic                 i_clip_near = 1'b0;
    logic                 i_clip_far = 1'b0;
    logic                 i_last_vertex = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [CW-1:0] o_out_x;
    logic signed [CW-1:0] o_out_y;
    logic signed [CW-1:0] o_out_z;
    logic                 o_poly_end;
    logic                 o_all_clipped;

    polygon_depth_plane_clipper #(.COORD_WIDTH(CW)) u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // clip model state
    logic signed [CW-1:0] near_z;
    logic signed [CW-1:0] far_z;
    vert_t                prev_v [2];
    logic                 prev_in [2];
    vert_t                first_out [2];
    logic                 need_close [2];
    logic                 emitted [2];
    logic                 started [2];
    logic [1:0]           plane_en;
    vert_t                near_out_q [$];
    vert_t                far_out_q [$];

    clip_res_t pending_results [$];
    int        errors = 0;
    int        idle_cycles = 0;

    function automatic logic plane_inside(int k, vert_t v);
        if (k == 0) return v.z < near_z;
        return v.z > far_z;
    endfunction

    function automatic logic signed [CW-1:0] sat_quot(longint num, longint den);
        longint q;
        if (den == 0) q = (num > 0) ? 32767 : (num < 0 ? -32768 : 0);
        else q = num / den;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[CW-1:0];
    endfunction

    function automatic vert_t plane_cross(int k, vert_t s, vert_t e);
        logic signed [CW-1:0] pz;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] dz;
        logic signed [CW-1:0] n;
        vert_t o;
        pz = (k == 0) ? near_z : far_z;
        dx = e.x - s.x;
        dy = e.y - s.y;
        dz = e.z - s.z;
        n  = pz - s.z;
        o.x = s.x + sat_quot(longint'(dx) * longint'(n), longint'(dz));
        o.y = s.y + sat_quot(longint'(dy) * longint'(n), longint'(dz));
        o.z = pz;
        return o;
    endfunction

    function automatic void stage_emit(int k, vert_t v);
        if (!emitted[k]) begin
            first_out[k] = v;
            emitted[k] = 1'b1;
        end
        if (k == 0) near_out_q.push_back(v);
        else far_out_q.push_back(v);
    endfunction

    function automatic void stage_take(int k, vert_t v);
        logic ins;
        ins = plane_en[k] ? plane_inside(k, v) : 1'b1;
        if (!started[k]) begin
            started[k] = 1'b1;
            emitted[k] = 1'b0;
            need_close[k] = !ins;
            if (ins) stage_emit(k, v);
        end else if (prev_in[k] && ins) begin
            stage_emit(k, v);
        end else if (prev_in[k] && !ins) begin
            stage_emit(k, plane_cross(k, prev_v[k], v));
        end else if (!prev_in[k] && ins) begin
            stage_emit(k, plane_cross(k, v, prev_v[k]));
            stage_emit(k, v);
        end
        prev_v[k] = v;
        prev_in[k] = ins;
    endfunction

    function automatic void stage_close(int k);
        if (need_close[k] && emitted[k]) stage_emit(k, first_out[k]);
        started[k] = 1'b0;
        emitted[k] = 1'b0;
        need_close[k] = 1'b0;
    endfunction

    // run one accepted vertex beat through the model, queue what it yields
    function automatic void clip_predict(vert_t v, logic cn, logic cf, logic last,
                                         logic keep);
        vert_t     m;
        clip_res_t r;
        if (!started[0]) plane_en = {cf, cn};
        near_out_q.delete();
        far_out_q.delete();
        stage_take(0, v);
        if (last) stage_close(0);
        while (near_out_q.size() > 0) begin
            m = near_out_q.pop_front();
            stage_take(1, m);
        end
        if (last) stage_close(1);
        if (!keep) return;
        if (last && far_out_q.size() == 0) begin
            r = '{x: '0, y: '0, z: '0, pend: 1'b1, clipped: 1'b1};
            pending_results.push_back(r);
        end
        for (int i = 0; i < far_out_q.size(); i++) begin
            r.x = far_out_q[i].x;
            r.y = far_out_q[i].y;
            r.z = far_out_q[i].z;
            r.pend = last && (i == far_out_q.size() - 1);
            r.clipped = 1'b0;
            pending_results.push_back(r);
        end
    endfunction

    initial begin
        near_z = 16'sd0;
        far_z = -16'sd32768;
        plane_en = 2'b00;
        for (int k = 0; k < 2; k++) begin
            prev_v[k] = '{x: '0, y: '0, z: '0};
            first_out[k] = '{x: '0, y: '0, z: '0};
            prev_in[k] = 1'b0;
            need_close[k] = 1'b0;
            emitted[k] = 1'b0;
            started[k] = 1'b0;
        end
    end

    // result side: check, stall, watchdog
    int stall_left = 0;

    always @(posedge i_clk) begin
        clip_res_t e;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL polygon_depth_plane_clipper");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected beat x=%0d y=%0d z=%0d end=%0b clip=%0b",
                             $time, o_out_x, o_out_y, o_out_z, o_poly_end, o_all_clipped);
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    if (o_all_clipped !== e.clipped) begin
                        $display("%0t: all_clipped exp %0b got %0b", $time, e.clipped,
                                 o_all_clipped);
                        errors++;
                    end
                    if (o_poly_end !== e.pend) begin
                        $display("%0t: poly_end exp %0b got %0b", $time, e.pend, o_poly_end);
                        errors++;
                    end
                    if (o_out_x !== e.x) begin
                        $display("%0t: out_x exp %0d got %0d", $time, e.x, o_out_x);
                        errors++;
                    end
                    if (o_out_y !== e.y) begin
                        $display("%0t: out_y exp %0d got %0d", $time, e.y, o_out_y);
                        errors++;
                    end
                    if (o_out_z !== e.z) begin
                        $display("%0t: out_z exp %0d got %0d", $time, e.z, o_out_z);
                        errors++;
                    end
                end
            end
        end
        // hold ready low for a random stretch now and then
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    int gap_mode = 0;

    task automatic send_vertex(vert_t v, logic cn, logic cf, logic last);
        int gap;
        gap = 0;
        if (gap_mode != 0 && $urandom_range(0, 99) < 30)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vert_x <= v.x;
        i_vert_y <= v.y;
        i_vert_z <= v.z;
        i_clip_near <= cn;
        i_clip_far <= cf;
        i_last_vertex <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic plane_write(logic [pdpc_pkg::CFG_IDX_W-1:0] idx,
                               logic signed [CW-1:0] val);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        if (idx == pdpc_pkg::REG_NEAR) near_z = val;
        else far_z = val;
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        if ($urandom_range(0, 1) == 0) return CW'($urandom());
        return $signed(16'($urandom_range(0, 400))) - 16'sd200;
    endfunction

    function automatic logic signed [CW-1:0] rand_depth();
        case ($urandom_range(0, 3))
            0: return near_z + $signed(16'($urandom_range(0, 200))) - 16'sd100;
            1: return far_z + $signed(16'($urandom_range(0, 200))) - 16'sd100;
            2: return CW'($urandom());
            default: return (near_z >>> 1) + (far_z >>> 1);
        endcase
    endfunction

    function automatic vert_t rand_vertex();
        vert_t v;
        v.x = rand_coord();
        v.y = rand_coord();
        v.z = rand_depth();
        return v;
    endfunction

    task automatic send_checked(vert_t v, logic cn, logic cf, logic last);
        send_vertex(v, cn, cf, last);
        clip_predict(v, cn, cf, last, 1'b1);
    endtask

    task automatic send_polygon(output int cnt);
        vert_t first;
        logic  cn;
        logic  cf;
        int    nv;
        cn = 1'($urandom_range(0, 1));
        cf = 1'($urandom_range(0, 1));
        nv = $urandom_range(0, 5);
        first = rand_vertex();
        cnt = nv + 1;
        if (nv == 0) begin
            send_checked(first, cn, cf, 1'b1);
            return;
        end
        send_checked(first, cn, cf, 1'b0);
        for (int i = 1; i < nv; i++)
            send_checked(rand_vertex(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'b0);
        send_checked(first, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    vec_row_t dir_rows [$];

    function automatic vec_row_t mk_row(int x, int y, int z, bit cn, bit cf, bit last);
        vec_row_t r;
        r.x = CW'(x);
        r.y = CW'(y);
        r.z = CW'(z);
        r.cn = cn;
        r.cf = cf;
        r.last = last;
        r.typed = 1'b0;
        r.res = '{x: '0, y: '0, z: '0, pend: 1'b0, clipped: 1'b0};
        return r;
    endfunction

    function automatic vec_row_t mk_typed(int x, int y, int z, bit cn, bit cf,
                                          int ex, int ey, int ez, bit ec);
        vec_row_t r;
        r = mk_row(x, y, z, cn, cf, 1'b1);
        r.typed = 1'b1;
        r.res = '{x: CW'(ex), y: CW'(ey), z: CW'(ez), pend: 1'b1, clipped: ec};
        return r;
    endfunction

    initial begin
        vert_t v;
        int    sent;
        int    n_sent;
        logic signed [CW-1:0] phase_near [6];
        logic signed [CW-1:0] phase_far [6];

        // single-vertex polygons at reset planes: pass-through, clipped, extremes
        dir_rows.push_back(mk_typed(100, -200, 7, 0, 0, 100, -200, 7, 0));
        dir_rows.push_back(mk_typed(1, 2, 5, 1, 0, 0, 0, 0, 1));
        dir_rows.push_back(mk_typed(-32768, 32767, -32768, 1, 1, 0, 0, 0, 1));
        dir_rows.push_back(mk_typed(32767, -32768, -1, 1, 1, 32767, -32768, -1, 0));
        // triangle starting inside, crossing the near plane
        dir_rows.push_back(mk_row(0, 0, -10, 1, 1, 0));
        dir_rows.push_back(mk_row(100, 50, 10, 0, 0, 0));
        dir_rows.push_back(mk_row(-100, 80, -20, 0, 0, 0));
        dir_rows.push_back(mk_row(0, 0, -10, 0, 0, 1));
        // triangle starting outside: closes with its first emitted vertex
        dir_rows.push_back(mk_row(10, 10, 20, 1, 0, 0));
        dir_rows.push_back(mk_row(-30, 40, -40, 1, 1, 0));
        dir_rows.push_back(mk_row(50, -60, -5, 0, 1, 0));
        dir_rows.push_back(mk_row(10, 10, 20, 1, 1, 1));
        // extreme spans: wrapped differences and saturating quotient
        dir_rows.push_back(mk_row(32767, -32768, -32768, 1, 0, 0));
        dir_rows.push_back(mk_row(-32768, 32767, 32767, 0, 1, 0));
        dir_rows.push_back(mk_row(32767, -32768, -32768, 0, 0, 1));
        // fully clipped two-vertex polygon with both planes
        dir_rows.push_back(mk_row(5, 5, 100, 1, 1, 0));
        dir_rows.push_back(mk_row(-5, 5, 200, 0, 0, 0));
        dir_rows.push_back(mk_row(5, 5, 100, 0, 0, 1));

        phase_near = '{16'sd0, 16'sd1000, 16'sd32767, -16'sd32768, 16'sd0, 16'sd500};
        phase_far = '{-16'sd32768, -16'sd1000, -16'sd32768, 16'sd32767, 16'sd0, -16'sd300};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            v = '{x: dir_rows[i].x, y: dir_rows[i].y, z: dir_rows[i].z};
            send_vertex(v, dir_rows[i].cn, dir_rows[i].cf, dir_rows[i].last);
            clip_predict(v, dir_rows[i].cn, dir_rows[i].cf, dir_rows[i].last,
                         !dir_rows[i].typed);
            if (dir_rows[i].typed) pending_results.push_back(dir_rows[i].res);
        end
        drain_and_settle();

        gap_mode = 1;
        for (int p = 0; p < 6; p++) begin
            plane_write(pdpc_pkg::REG_NEAR,
                        (p == 5) ? $signed(16'($urandom())) : phase_near[p]);
            plane_write(pdpc_pkg::REG_FAR,
                        (p == 5) ? $signed(16'($urandom())) : phase_far[p]);
            gap_mode = (p == 2) ? 0 : 1;
            sent = 0;
            while (sent < 44) begin
                if ($urandom_range(0, 9) == 0) begin
                    // loose beat with random fields, may leave a polygon open
                    v.x = CW'($urandom());
                    v.y = CW'($urandom());
                    v.z = CW'($urandom());
                    send_checked(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    send_polygon(n_sent);
                    sent += n_sent;
                end
            end
            drain_and_settle();
        end

        if (errors == 0) begin
            $display("PASS polygon_depth_plane_clipper");
        end else begin
            $display("FAIL polygon_depth_plane_clipper");
        end
        $finish;
    end

endmodule
